// ----- design/chbd_pkg.sv -----
// Package for the chunked body decoder: parse phases, result codes, the result word
// and the byte class helpers. No dependencies.
`default_nettype none
package chbd_pkg;

  localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

  typedef enum logic [3:0] {
    PH_SIZE_START = 4'd0,
    PH_SIZE       = 4'd1,
    PH_SIZE_LF    = 4'd2,
    PH_EXT        = 4'd3,
    PH_DATA       = 4'd4,
    PH_DATA_CR    = 4'd5,
    PH_DATA_LF    = 4'd6,
    PH_LAST       = 4'd7,
    PH_LAST_LF    = 4'd8,
    PH_LAST_EXT   = 4'd9,
    PH_TR_START   = 4'd10,
    PH_NAME       = 4'd11,
    PH_VALUE      = 4'd12,
    PH_VALUE_LF   = 4'd13,
    PH_LINE_START = 4'd14,
    PH_END_LF     = 4'd15
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_SYNTAX   = 2'd0,
    ERR_LARGE    = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    err_t       code;
  } result_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  function automatic logic is_tchar(input logic [7:0] b);
    logic r;
    r = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
        (b >= 8'h41 && b <= 8'h5A);
    case (b)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
      8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB);
  endfunction

  function automatic logic is_vchar(input logic [7:0] b);
    return (b >= 8'h21 && b <= 8'h7E) || (b >= 8'h80);
  endfunction

endpackage
`default_nettype wire

// ----- design/chbd_if.sv -----
// Channel interfaces for the chunked body decoder: raw byte words in, result words out.
// No dependencies.
`default_nettype none
interface chbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       message_start;
  modport source (output valid, output raw_byte, output message_start, input ready);
  modport sink (input valid, input raw_byte, input message_start, output ready);
endinterface

interface chbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [1:0] error_code;
  modport source (output valid, output kind, output data_byte, output error_code,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input error_code,
                output ready);
endinterface
`default_nettype wire

// ----- design/chbd_parser.sv -----
// Input register and per-byte parser of the chunked body decoder.
// Depends on chbd_pkg.
`default_nettype none
module chbd_parser #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        raw_byte,
  input  wire logic              message_start,
  input  wire logic [31:0]       max_body_bytes,
  input  wire logic              buf_full,
  output logic                   push,
  output chbd_pkg::result_t      res
);
  import chbd_pkg::*;

  logic                 s_valid_r, s_valid_nxt;
  logic [7:0]           s_byte_r;
  logic                 s_start_r;
  phase_t               ph_r, ph_nxt, ph_c;
  logic [SIZE_BITS-1:0] chunk_r, chunk_nxt;
  logic [SIZE_BITS-1:0] dr_r, dr_nxt;
  logic [32:0]          raw_r, raw_nxt, raw_c, raw_inc;
  logic                 saw_r, saw_nxt;
  logic                 fin_r, fin_nxt, fin_c;
  logic                 advance;
  logic [4:0]           hv;
  logic [7:0]           b;
  logic                 do_err, do_data, do_end;
  err_t                 err_code;

  assign advance  = s_valid_r && !buf_full;
  assign in_ready = !s_valid_r || advance;
  assign b        = s_byte_r;
  assign hv       = hex_value(b);
  assign ph_c     = s_start_r ? PH_SIZE_START : ph_r;
  assign fin_c    = s_start_r ? 1'b0 : fin_r;
  assign raw_c    = s_start_r ? 33'd0 : raw_r;
  assign raw_inc  = raw_c + 33'd1;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_valid && in_ready) begin
      s_valid_nxt = 1'b1;
    end else if (advance) begin
      s_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    ph_nxt    = ph_r;
    chunk_nxt = chunk_r;
    dr_nxt    = dr_r;
    raw_nxt   = raw_r;
    saw_nxt   = saw_r;
    fin_nxt   = fin_r;
    do_err    = 1'b0;
    do_data   = 1'b0;
    do_end    = 1'b0;
    err_code  = ERR_SYNTAX;
    if (advance) begin
      if (s_start_r) begin
        ph_nxt    = PH_SIZE_START;
        chunk_nxt = '0;
        dr_nxt    = '0;
        raw_nxt   = '0;
        saw_nxt   = 1'b0;
        fin_nxt   = 1'b0;
      end
      if (!fin_c) begin
        raw_nxt = raw_inc;
        if (raw_inc > {1'b0, max_body_bytes}) begin
          do_err   = 1'b1;
          err_code = ERR_LARGE;
        end else begin
          case (ph_c)
            PH_SIZE_START: begin
              if (b == CH_ZERO) begin
                ph_nxt = PH_LAST;
              end else if (!hv[4]) begin
                do_err = 1'b1;
              end else begin
                chunk_nxt = {{(SIZE_BITS-4){1'b0}}, hv[3:0]};
                ph_nxt    = PH_SIZE;
              end
            end
            PH_SIZE: begin
              if (hv[4]) begin
                if (chunk_r[SIZE_BITS-1 -: 4] != 4'd0) begin
                  do_err   = 1'b1;
                  err_code = ERR_OVERFLOW;
                end else begin
                  chunk_nxt = {chunk_r[SIZE_BITS-5:0], hv[3:0]};
                end
              end else if (b == CH_SEMI) begin
                saw_nxt = 1'b0;
                ph_nxt  = PH_EXT;
              end else if (b == CH_CR) begin
                ph_nxt = PH_SIZE_LF;
              end else begin
                do_err = 1'b1;
              end
            end
            PH_SIZE_LF: begin
              if (b != CH_LF) begin
                do_err = 1'b1;
              end else begin
                dr_nxt = chunk_r;
                ph_nxt = (chunk_r != '0) ? PH_DATA : PH_DATA_CR;
              end
            end
            PH_EXT: begin
              if (saw_r && b == CH_LF) begin
                saw_nxt = 1'b0;
                dr_nxt  = chunk_r;
                ph_nxt  = (chunk_r != '0) ? PH_DATA : PH_DATA_CR;
              end else begin
                saw_nxt = (b == CH_CR);
              end
            end
            PH_DATA: begin
              dr_nxt  = dr_r - {{(SIZE_BITS-1){1'b0}}, 1'b1};
              do_data = 1'b1;
              if (dr_r == {{(SIZE_BITS-1){1'b0}}, 1'b1}) begin
                ph_nxt = PH_DATA_CR;
              end
            end
            PH_DATA_CR: begin
              if (b != CH_CR) do_err = 1'b1;
              else ph_nxt = PH_DATA_LF;
            end
            PH_DATA_LF: begin
              if (b != CH_LF) begin
                do_err = 1'b1;
              end else begin
                chunk_nxt = '0;
                ph_nxt    = PH_SIZE_START;
              end
            end
            PH_LAST: begin
              if (b == CH_ZERO) begin
                ph_nxt = PH_LAST;
              end else if (b == CH_SEMI) begin
                saw_nxt = 1'b0;
                ph_nxt  = PH_LAST_EXT;
              end else if (b == CH_CR) begin
                ph_nxt = PH_LAST_LF;
              end else begin
                do_err = 1'b1;
              end
            end
            PH_LAST_LF: begin
              if (b != CH_LF) do_err = 1'b1;
              else ph_nxt = PH_TR_START;
            end
            PH_LAST_EXT: begin
              if (saw_r && b == CH_LF) begin
                saw_nxt = 1'b0;
                ph_nxt  = PH_TR_START;
              end else begin
                saw_nxt = (b == CH_CR);
              end
            end
            PH_TR_START, PH_LINE_START: begin
              if (ph_c == PH_LINE_START && is_ws(b)) begin
                ph_nxt = PH_VALUE;
              end else if (is_tchar(b)) begin
                ph_nxt = PH_NAME;
              end else if (b == CH_CR) begin
                ph_nxt = PH_END_LF;
              end else begin
                do_err = 1'b1;
              end
            end
            PH_NAME: begin
              if (is_tchar(b)) begin
                ph_nxt = PH_NAME;
              end else if (b == CH_COLON) begin
                ph_nxt = PH_VALUE;
              end else begin
                do_err = 1'b1;
              end
            end
            PH_VALUE: begin
              if (is_ws(b) || is_vchar(b)) begin
                ph_nxt = PH_VALUE;
              end else if (b == CH_CR) begin
                ph_nxt = PH_VALUE_LF;
              end else begin
                do_err = 1'b1;
              end
            end
            PH_VALUE_LF: begin
              if (b != CH_LF) do_err = 1'b1;
              else ph_nxt = PH_LINE_START;
            end
            PH_END_LF: begin
              if (b != CH_LF) begin
                do_err = 1'b1;
              end else begin
                fin_nxt = 1'b1;
                do_end  = 1'b1;
              end
            end
            default: do_err = 1'b1;
          endcase
        end
        if (do_err) fin_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    push     = do_err || do_data || do_end;
    res.kind = do_err ? KIND_ERR : (do_end ? KIND_END : KIND_DATA);
    res.data = do_data ? b : 8'd0;
    res.code = do_err ? err_code : ERR_SYNTAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      ph_r      <= PH_SIZE_START;
      chunk_r   <= '0;
      dr_r      <= '0;
      raw_r     <= '0;
      saw_r     <= 1'b0;
      fin_r     <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
      ph_r      <= ph_nxt;
      chunk_r   <= chunk_nxt;
      dr_r      <= dr_nxt;
      raw_r     <= raw_nxt;
      saw_r     <= saw_nxt;
      fin_r     <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_byte_r  <= raw_byte;
      s_start_r <= message_start;
    end
  end

endmodule
`default_nettype wire

// ----- design/chbd_out_buf.sv -----
// Two-word result buffer: a two-entry FIFO with read and write pointers.
// Depends on chbd_pkg.
`default_nettype none
module chbd_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire chbd_pkg::result_t push_res,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output chbd_pkg::result_t      out_res
);
  import chbd_pkg::*;

  result_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

endmodule
`default_nettype wire

// ----- design/http_chunked_body_decoder.sv -----
// Top level of the chunked body decoder: size register, parser and result buffer.
// Depends on chbd_pkg, chbd_if, chbd_parser and chbd_out_buf.
//
// Takes one raw byte of a chunked message per cycle unless the result buffer is full, and
// gives at most one word per byte: a body data byte, the end of body, or an error with its
// code. A byte is held in the input register when it is taken and parsed straight out of
// it, and its result word goes into the result buffer and is offered on the output.
// The two-word result buffer keeps parsing going while one result waits; input stalls
// once both entries are occupied. After an end or an error, bytes are taken and dropped
// until one arrives with message_start set.
`default_nettype none
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  chbd_in_if.sink          in_ch,
  chbd_out_if.source       out_ch,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);
  import chbd_pkg::*;

  logic [31:0] max_body_r;
  logic        push;
  logic        full;
  result_t     push_res;
  result_t     out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= MAX_BODY_RESET;
    end else if (cfg_wr_en) begin
      max_body_r <= cfg_wr_data;
    end
  end

  chbd_parser #(.SIZE_BITS(SIZE_BITS)) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .raw_byte       (in_ch.raw_byte),
    .message_start  (in_ch.message_start),
    .max_body_bytes (max_body_r),
    .buf_full       (full),
    .push           (push),
    .res            (push_res)
  );

  chbd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .full      (full),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.kind       = out_res.kind;
  assign out_ch.data_byte  = out_res.data;
  assign out_ch.error_code = out_res.code;

endmodule
`default_nettype wire

// ----- design/chbd_checker.sv -----
// Port checker for the chunked body decoder, bound to the top level.
// Depends on chbd_pkg and http_chunked_body_decoder.
`default_nettype none
module chbd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] kind,
  input wire logic [7:0] data_byte,
  input wire logic [1:0] error_code
);
  import chbd_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte)
      && $stable(error_code))
    else $error("stalled result word changed");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (kind == KIND_DATA || kind == KIND_END || kind == KIND_ERR))
    else $error("result kind out of range");

  a_data_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != KIND_DATA |-> data_byte == 8'd0)
    else $error("data byte set on a non-data word");

  a_code_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != KIND_ERR |-> error_code == ERR_SYNTAX)
    else $error("error code set on a non-error word");

endmodule

bind http_chunked_body_decoder chbd_checker u_chbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .kind       (out_ch.kind),
  .data_byte  (out_ch.data_byte),
  .error_code (out_ch.error_code)
);
`default_nettype wire

// ----- test/tb_http_chunked_body_decoder.sv -----
// Testbench for http_chunked_body_decoder: chunked messages in, data, end and error words out,
// checked against a decoder state machine kept in the bench.
// Depends on chbd_pkg, chbd_in_if, chbd_out_if and the decoder RTL.
module tb_http_chunked_body_decoder;
  import chbd_pkg::*;

  localparam int SIZE_W       = 32;
  localparam int SETTLE_TICKS = 8;
  localparam int HOLD_LEN     = 90;
  localparam int QUIET_LIMIT  = 2000;
  localparam int IDLE_PCT     = 31;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  chbd_in_if  in_ch ();
  chbd_out_if out_ch ();

  http_chunked_body_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // decoder state mirrored in the bench
  phase_t      ps;
  logic [31:0] csize;
  logic [31:0] left;
  logic [32:0] taken;
  logic        cr_seen;
  logic        halted;
  logic [31:0] body_limit;

  result_t     pending_results[$];
  result_t     want;
  logic [7:0]  frame[$];

  int  sent_count;
  int  mismatches;
  int  n_data;
  int  n_end;
  int  n_err;
  int  quiet_cycles;
  int  hold_left;
  bit  calm;
  logic hold_go;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void parse_reset();
    ps      = PH_SIZE_START;
    csize   = '0;
    left    = '0;
    taken   = '0;
    cr_seen = 1'b0;
    halted  = 1'b0;
  endfunction

  function automatic int nib(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  function automatic bit token_char(input logic [7:0] c);
    string marks = "!#$%&'*+-.^_|~";
    if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
      return 1'b1;
    if (c == 8'h60) return 1'b1;
    for (int i = 0; i < marks.len(); i++)
      if (marks[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  function automatic bit visible(input logic [7:0] c);
    return (c >= 8'h21 && c != 8'h7F);
  endfunction

  function automatic bit flag_error(output result_t r, input err_t code);
    halted = 1'b1;
    r      = '0;
    r.kind = KIND_ERR;
    r.code = code;
    return 1'b1;
  endfunction

  function automatic bit ext_end(input logic [7:0] c);
    if (cr_seen && c == CH_LF) begin
      cr_seen = 1'b0;
      return 1'b1;
    end
    cr_seen = (c == CH_CR);
    return 1'b0;
  endfunction

  function automatic void open_data();
    left = csize;
    ps   = (left != 0) ? PH_DATA : PH_DATA_CR;
  endfunction

  // advance the decoder by one raw byte; returns 1 when a result word is due
  function automatic bit decode_step(input logic [7:0] c, input logic st, output result_t r);
    int d;
    r = '0;
    if (st) parse_reset();
    if (halted) return 1'b0;
    taken++;
    if (taken > {1'b0, body_limit}) return flag_error(r, ERR_LARGE);
    d = nib(c);
    case (ps)
      PH_SIZE_START: begin
        if (c == CH_ZERO) ps = PH_LAST;
        else if (d < 0) return flag_error(r, ERR_SYNTAX);
        else begin
          csize = 32'(d);
          ps    = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if (d >= 0) begin
          if ((csize >> (SIZE_W - 4)) != 0) return flag_error(r, ERR_OVERFLOW);
          csize = {csize[27:0], 4'(d)};
        end else if (c == CH_SEMI) begin
          cr_seen = 1'b0;
          ps      = PH_EXT;
        end else if (c == CH_CR) ps = PH_SIZE_LF;
        else return flag_error(r, ERR_SYNTAX);
      end
      PH_SIZE_LF: begin
        if (c != CH_LF) return flag_error(r, ERR_SYNTAX);
        open_data();
      end
      PH_EXT: begin
        if (ext_end(c)) open_data();
      end
      PH_DATA: begin
        left--;
        if (left == 0) ps = PH_DATA_CR;
        r.kind = KIND_DATA;
        r.data = c;
        return 1'b1;
      end
      PH_DATA_CR: begin
        if (c != CH_CR) return flag_error(r, ERR_SYNTAX);
        ps = PH_DATA_LF;
      end
      PH_DATA_LF: begin
        if (c != CH_LF) return flag_error(r, ERR_SYNTAX);
        csize = '0;
        ps    = PH_SIZE_START;
      end
      PH_LAST: begin
        if (c == CH_ZERO) ;
        else if (c == CH_SEMI) begin
          cr_seen = 1'b0;
          ps      = PH_LAST_EXT;
        end else if (c == CH_CR) ps = PH_LAST_LF;
        else return flag_error(r, ERR_SYNTAX);
      end
      PH_LAST_LF: begin
        if (c != CH_LF) return flag_error(r, ERR_SYNTAX);
        ps = PH_TR_START;
      end
      PH_LAST_EXT: begin
        if (ext_end(c)) ps = PH_TR_START;
      end
      PH_LINE_START, PH_TR_START: begin
        if (ps == PH_LINE_START && blank(c)) ps = PH_VALUE;
        else if (token_char(c)) ps = PH_NAME;
        else if (c == CH_CR) ps = PH_END_LF;
        else return flag_error(r, ERR_SYNTAX);
      end
      PH_NAME: begin
        if (token_char(c)) ;
        else if (c == CH_COLON) ps = PH_VALUE;
        else return flag_error(r, ERR_SYNTAX);
      end
      PH_VALUE: begin
        if (blank(c) || visible(c)) ;
        else if (c == CH_CR) ps = PH_VALUE_LF;
        else return flag_error(r, ERR_SYNTAX);
      end
      PH_VALUE_LF: begin
        if (c != CH_LF) return flag_error(r, ERR_SYNTAX);
        ps = PH_LINE_START;
      end
      PH_END_LF: begin
        if (c != CH_LF) return flag_error(r, ERR_SYNTAX);
        halted = 1'b1;
        r.kind = KIND_END;
        return 1'b1;
      end
      default: return flag_error(r, ERR_SYNTAX);
    endcase
    return 1'b0;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
  endfunction

  function automatic void load_text(input string s);
    frame.delete();
    push_text(s);
  endfunction

  function automatic void push_crlf();
    frame.push_back(CH_CR);
    frame.push_back(CH_LF);
  endfunction

  function automatic logic [7:0] any_blank();
    return $urandom_range(1) ? CH_SP : CH_TAB;
  endfunction

  function automatic logic [7:0] any_visible();
    logic [7:0] c;
    c = 8'($urandom_range(8'h21, 8'hFF));
    if (c == 8'h7F) c = 8'h80;
    return c;
  endfunction

  function automatic void push_hex(input logic [31:0] v);
    bit         lead;
    logic [3:0] d;
    lead = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      d = v[i*4 +: 4];
      if (d != 0) lead = 1'b0;
      if (!lead)
        frame.push_back(d < 10 ? 8'h30 + 8'(d) : ($urandom_range(1) ? 8'h57 : 8'h37) + 8'(d));
    end
  endfunction

  function automatic void push_extension();
    frame.push_back(CH_SEMI);
    repeat ($urandom_range(0, 5)) frame.push_back(8'($urandom_range(8'h20, 8'h7E)));
  endfunction

  function automatic void push_field();
    string names = "abcxyzQRZ0189!#$%&'*+-.^_|~";
    repeat ($urandom_range(1, 4)) frame.push_back(names[$urandom_range(names.len() - 1)]);
    frame.push_back(CH_COLON);
    repeat ($urandom_range(0, 5))
      frame.push_back($urandom_range(2) == 0 ? any_blank() : any_visible());
    if ($urandom_range(4) == 0) begin
      push_crlf();
      frame.push_back(any_blank());
      repeat ($urandom_range(1, 3)) frame.push_back(any_visible());
    end
    push_crlf();
  endfunction

  function automatic void build_message();
    int sz;
    frame.delete();
    repeat ($urandom_range(0, 3)) begin
      sz = ($urandom_range(9) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 12);
      push_hex(32'(sz));
      if ($urandom_range(3) == 0) push_extension();
      push_crlf();
      repeat (sz) frame.push_back(8'($urandom_range(255)));
      push_crlf();
    end
    repeat ($urandom_range(1, 3)) frame.push_back(CH_ZERO);
    if ($urandom_range(4) == 0) push_extension();
    push_crlf();
    repeat ($urandom_range(0, 2)) push_field();
    push_crlf();
  endfunction

  task automatic send_word(input logic [7:0] b, input logic st);
    result_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.raw_byte      <= b;
    in_ch.message_start <= st;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
    if (decode_step(b, st, r)) pending_results.push_back(r);
  endtask

  task automatic send_frame(input bit mangle);
    int pos;
    if (mangle && frame.size() > 0) begin
      pos = $urandom_range(frame.size() - 1);
      if ($urandom_range(1)) frame[pos] = 8'($urandom_range(255));
      else while (frame.size() > pos + 1) void'(frame.pop_back());
    end
    foreach (frame[i]) send_word(frame[i], i == 0);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_body_limit(input logic [31:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    body_limit = v;
  endtask

  task automatic test_directed();
    frame.delete();
    push_text("1");
    push_crlf();
    frame.push_back(8'hFF);
    push_crlf();
    push_text("0");
    push_crlf();
    push_crlf();
    send_frame(1'b0);
    send_word(8'h00, 1'b0);
    frame.delete();
    push_text("3");
    push_crlf();
    push_text("ab");
    send_frame(1'b0);
    load_text("00x");
    send_frame(1'b0);
    frame.delete();
    push_text("0");
    push_crlf();
    push_text(":");
    send_frame(1'b0);
    load_text("Ab3F9e2C7");
    send_frame(1'b0);
    settle();
  endtask

  task automatic test_random_traffic(input int goal);
    int first;
    first = sent_count;
    while (sent_count - first < goal) begin
      build_message();
      send_frame($urandom_range(99) < 25);
      if ($urandom_range(99) < 30)
        repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(255)), 1'b0);
    end
    settle();
  endtask

  task automatic test_body_limit();
    write_body_limit(32'd0);
    frame.delete();
    push_text("0");
    push_crlf();
    push_crlf();
    send_frame(1'b0);
    load_text("5x");
    send_frame(1'b0);
    settle();
    write_body_limit(32'd6);
    frame.delete();
    push_text("1");
    push_crlf();
    push_text("Z");
    push_crlf();
    push_text("0");
    push_crlf();
    push_crlf();
    send_frame(1'b0);
    settle();
    write_body_limit(32'hFFFF_FFFF);
    test_random_traffic(40);
    write_body_limit(32'd24);
    test_random_traffic(100);
    write_body_limit(MAX_BODY_RESET);
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    frame.delete();
    push_text("30");
    push_crlf();
    repeat (48) frame.push_back(8'($urandom_range(255)));
    push_crlf();
    push_text("0");
    push_crlf();
    push_crlf();
    hold_go <= 1'b1;
    send_frame(1'b0);
    settle();
    test_random_traffic(70);
    calm = 1'b0;
  endtask

  // result sink: random stalls, plus one long hold on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go  <= 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (calm) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word: kind %0d data %02h code %0d",
                   out_ch.kind, out_ch.data_byte, out_ch.error_code);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.kind !== want.kind || out_ch.data_byte !== want.data ||
            out_ch.error_code !== want.code) begin
          if (mismatches < 10)
            $display({"word mismatch: expected kind %0d data %02h code %0d,",
                      " got kind %0d data %02h code %0d"},
                     want.kind, want.data, want.code,
                     out_ch.kind, out_ch.data_byte, out_ch.error_code);
          mismatches++;
        end
        case (want.kind)
          KIND_DATA: n_data++;
          KIND_END:  n_end++;
          default:   n_err++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.raw_byte      = '0;
    in_ch.message_start = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    hold_go             = 1'b0;
    hold_left           = 0;
    calm                = 1'b0;
    sent_count          = 0;
    mismatches          = 0;
    n_data              = 0;
    n_end               = 0;
    n_err               = 0;
    quiet_cycles        = 0;
    body_limit          = MAX_BODY_RESET;
    parse_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_body_limit();
    test_random_traffic(70);
    test_backpressure();
    $display("%0d raw bytes taken; %0d data, %0d end and %0d error words checked",
             sent_count, n_data, n_end, n_err);
    $display("size limits 0, 6, 24, reset value and all ones; one long output hold");
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ----- http_chunked_body_decoder.f -----
design/chbd_pkg.sv
design/chbd_if.sv
design/chbd_parser.sv
design/chbd_out_buf.sv
design/http_chunked_body_decoder.sv
design/chbd_checker.sv
test/tb_http_chunked_body_decoder.sv
